// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands for the checker file ldw_checker.sv.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop on every rising edge, skipped while reset is asserted.
`define LDW_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error(msg);

// Check prop on every rising edge, reset included.
`define LDW_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

// ===== hw/rtl/ldw_pkg.sv =====
// ----------------------------------------------------------------------------
// ldw_pkg
// Shared constants of the longest distinct window block.
// ----------------------------------------------------------------------------
`default_nettype none

package ldw_pkg;

    // Width of the reported length and the largest value it can carry.
    localparam int LONGEST_W   = 11;
    localparam int LONGEST_MAX = 2047;

endpackage

`default_nettype wire

// ===== hw/rtl/ldw_ram.sv =====
// ----------------------------------------------------------------------------
// ldw_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module ldw_ram #(
    parameter int ADDR_BITS = 10,
    parameter int DATA_BITS = 32
) (
    input  wire logic                 aclk,
    input  wire logic                 rd_en,
    input  wire logic [ADDR_BITS-1:0] rd_addr,
    output logic      [DATA_BITS-1:0] rd_data,
    input  wire logic                 wr_en,
    input  wire logic [ADDR_BITS-1:0] wr_addr,
    input  wire logic [DATA_BITS-1:0] wr_data
);

    logic [DATA_BITS-1:0] mem [2**ADDR_BITS];

    // Read returns the old contents when the same entry is written this cycle.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/longest_distinct_window.sv =====
// Pipeline: stage 1, then the output register. Throughput: one item per cycle
//   unless the output stalls; the last-seen table takes one read and one
//   write per item, and a one-entry forward register covers equal neighbors.
// Reset: synchronous, active low. After reset the table is swept to zero,
//   one entry per cycle over all 2**VALUE_BITS entries, s_ready held low.
// ----------------------------------------------------------------------------
// longest_distinct_window
// Streaming length of the longest run of pairwise distinct values.
// ----------------------------------------------------------------------------
`default_nettype none

module longest_distinct_window #(
    parameter int VALUE_BITS = 10,
    parameter int POS_BITS   = 32
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // input beats
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [VALUE_BITS-1:0]         s_value,
    input  wire logic                          s_first_item,
    input  wire logic                          s_last_item,
    // result beats
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [ldw_pkg::LONGEST_W-1:0]      m_longest,
    output logic                               m_final_result,
    output logic                               m_count_overflow
);

    // A window can never exceed the table depth nor what m_longest carries.
    localparam int TableDepth = 1 << VALUE_BITS;
    localparam int LenCap     = (TableDepth < ldw_pkg::LONGEST_MAX) ?
                                TableDepth : ldw_pkg::LONGEST_MAX;
    localparam int LW         = ldw_pkg::LONGEST_W;

    // ------------------------------------------------------------------
    // Clearing sweep: the counter's top bit marks the sweep as done.
    // ------------------------------------------------------------------
    logic [VALUE_BITS:0] clr_cnt_reg;
    logic                clearing;

    assign clearing = !clr_cnt_reg[VALUE_BITS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
        end else if (clearing) begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Handshake and stage control.
    // Stage 0 is the accept edge: the table read is launched and the
    // position counter advances. Stage 1 holds the read data, resolves the
    // window and writes the table back. The output register holds the
    // finished beat, so stage 1 moves whenever that register is free.
    // ------------------------------------------------------------------
    logic s1_valid_reg;
    logic s1_adv;
    logic out_free;
    logic accept;

    assign out_free = !m_valid || m_ready;
    assign s1_adv   = s1_valid_reg && out_free;
    assign s_ready  = !clearing && (!s1_valid_reg || out_free);
    assign accept   = s_valid && s_ready;

    // ------------------------------------------------------------------
    // Stage 0: position counter and wrap flag.
    // ------------------------------------------------------------------
    logic [POS_BITS-1:0]   position_reg;
    logic [POS_BITS-1:0]   pos_inc;
    logic                  wrapped_reg;
    logic                  wrapped_next;

    assign pos_inc      = position_reg + POS_BITS'(1);
    assign wrapped_next = wrapped_reg || (pos_inc == '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            position_reg <= '0;
            wrapped_reg  <= 1'b0;
        end else if (accept) begin
            position_reg <= pos_inc;
            wrapped_reg  <= wrapped_next;
        end
    end

    // Stage 1 payload: no reset needed, qualified by s1_valid_reg.
    logic [VALUE_BITS-1:0] s1_idx_reg;
    logic [POS_BITS-1:0]   s1_pos_reg;
    logic                  s1_first_reg;
    logic                  s1_last_reg;
    logic                  s1_wrap_reg;

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_idx_reg   <= s_value;
            s1_pos_reg   <= pos_inc;
            s1_first_reg <= s_first_item;
            s1_last_reg  <= s_last_item;
            s1_wrap_reg  <= wrapped_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (accept) begin
            s1_valid_reg <= 1'b1;
        end else if (s1_adv) begin
            s1_valid_reg <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Last-seen table. The write port serves the sweep, then stage 1.
    // ------------------------------------------------------------------
    logic [POS_BITS-1:0]   rd_data;
    logic                  wr_en;
    logic [VALUE_BITS-1:0] wr_addr;
    logic [POS_BITS-1:0]   wr_data;

    assign wr_en   = clearing || s1_adv;
    assign wr_addr = clearing ? clr_cnt_reg[VALUE_BITS-1:0] : s1_idx_reg;
    assign wr_data = clearing ? '0 : s1_pos_reg;

    ldw_ram #(
        .ADDR_BITS (VALUE_BITS),
        .DATA_BITS (POS_BITS)
    ) u_last_seen (
        .aclk    (aclk),
        .rd_en   (accept),
        .rd_addr (s_value),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    // ------------------------------------------------------------------
    // Forward register: the newest stage 1 write. The read for the next
    // item is launched on the same edge as this write and so misses it;
    // since it is always the newest write, a match is always correct.
    // ------------------------------------------------------------------
    logic                  fwd_valid_reg;
    logic [VALUE_BITS-1:0] fwd_idx_reg;
    logic [POS_BITS-1:0]   fwd_pos_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_valid_reg <= 1'b0;
        end else if (s1_adv) begin
            fwd_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_adv) begin
            fwd_idx_reg <= s1_idx_reg;
            fwd_pos_reg <= s1_pos_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: window resolution.
    // A first item restarts the window at its own position. A previous
    // sighting at or after the window start pulls the start just past it;
    // sightings from older sequences fall before the start and are ignored.
    // ------------------------------------------------------------------
    logic [POS_BITS-1:0] ws_reg;
    logic [LW-1:0]       best_reg;
    logic [POS_BITS-1:0] prev_pos;
    logic [POS_BITS-1:0] ws_base;
    logic [POS_BITS-1:0] ws_next;
    logic [POS_BITS-1:0] win_len;
    logic [LW-1:0]       len_sat;
    logic [LW-1:0]       best_base;
    logic [LW-1:0]       best_next;

    always_comb begin
        prev_pos  = (fwd_valid_reg && (fwd_idx_reg == s1_idx_reg)) ? fwd_pos_reg : rd_data;
        ws_base   = s1_first_reg ? s1_pos_reg : ws_reg;
        ws_next   = (prev_pos >= ws_base) ? (prev_pos + POS_BITS'(1)) : ws_base;
        win_len   = s1_pos_reg - ws_next + POS_BITS'(1);
        // clamp to the table depth and to the width of m_longest
        len_sat   = (win_len > POS_BITS'(LenCap)) ? LW'(LenCap) : win_len[LW-1:0];
        best_base = s1_first_reg ? '0 : best_reg;
        best_next = (len_sat > best_base) ? len_sat : best_base;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ws_reg   <= POS_BITS'(1);
            best_reg <= '0;
        end else if (s1_adv) begin
            ws_reg   <= ws_next;
            best_reg <= best_next;
        end
    end

    // ------------------------------------------------------------------
    // Output register: hold the beat until the consumer takes it.
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid <= 1'b0;
        end else if (s1_adv) begin
            m_valid <= 1'b1;
        end else if (m_ready) begin
            m_valid <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_adv) begin
            m_longest        <= best_next;
            m_final_result   <= s1_last_reg;
            m_count_overflow <= s1_wrap_reg;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/ldw_checker.sv =====
// ----------------------------------------------------------------------------
// ldw_checker
// Port-level checks of the longest distinct window block, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module ldw_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          s_ready,
    input wire logic                          m_valid,
    input wire logic                          m_ready,
    input wire logic [ldw_pkg::LONGEST_W-1:0] m_longest,
    input wire logic                          m_final_result,
    input wire logic                          m_count_overflow
);

    // A stalled result beat holds its payload.
    `LDW_ASSERT(a_hold_result, aclk, aresetn,
        m_valid && !m_ready |=> m_valid && $stable(m_longest) &&
            $stable(m_final_result) && $stable(m_count_overflow),
        "result beat changed while stalled")

    // Every window holds at least the current item.
    `LDW_ASSERT(a_longest_nonzero, aclk, aresetn,
        m_valid |-> m_longest != '0, "zero length reported")

    // Overflow is sticky until reset.
    `LDW_ASSERT(a_overflow_sticky, aclk, aresetn,
        $past(m_valid && m_count_overflow) && m_valid |-> m_count_overflow,
        "overflow flag dropped")

    // The table sweep blocks input right after reset.
    `LDW_ASSERT_ALWAYS(a_sweep_blocks, aclk,
        $rose(aresetn) |-> !s_ready && !m_valid, "input taken during table sweep")

endmodule

bind longest_distinct_window ldw_checker u_ldw_checker (.*);

`default_nettype wire

// ===== dv/tb_longest_distinct_window.sv =====
// ----------------------------------------------------------------------------
// tb_longest_distinct_window
// Self-checking bench for the streaming longest-distinct-window block. A
// directed table covers the value extremes, stale table entries, repeats and
// single-item sequences. Random sequences follow, plus one full permutation
// of every value so the window reaches its largest length. A predictor
// checks every result beat, and both channels stall at random.
// ----------------------------------------------------------------------------
module tb_longest_distinct_window;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int VALUE_BITS = 10;
    localparam int POS_BITS   = 32;
    localparam int DEPTH      = 1 << VALUE_BITS;
    localparam int LW         = ldw_pkg::LONGEST_W;
    localparam int IDLE_PCT   = 37;
    localparam int DIR_ROWS   = 20;
    localparam int RAND_ITEMS = 200;

    // One result beat as the block should present it.
    typedef struct packed {
        logic [LW-1:0] longest;
        logic          final_result;
        logic          count_overflow;
    } window_result_t;

    // One directed row; when known is set, longest is typed in by hand.
    typedef struct packed {
        logic [VALUE_BITS-1:0] value;
        logic                  first;
        logic                  last;
        logic                  known;
        logic [LW-1:0]         longest;
    } stim_row_t;

    logic                  aclk             = 1'b0;
    logic                  aresetn          = 1'b0;
    logic                  s_valid          = 1'b0;
    logic                  s_ready;
    logic [VALUE_BITS-1:0] s_value          = '0;
    logic                  s_first_item     = 1'b0;
    logic                  s_last_item      = 1'b0;
    logic                  m_valid;
    logic                  m_ready          = 1'b0;
    logic [LW-1:0]         m_longest;
    logic                  m_final_result;
    logic                  m_count_overflow;

    // Predictor state: position at which each value was last taken, the
    // running position, the current window start and the best run so far.
    logic [POS_BITS-1:0] seen_at [DEPTH];
    logic [POS_BITS-1:0] pos_count;
    logic [POS_BITS-1:0] run_start;
    logic [LW-1:0]       best_run;
    logic                pos_wrapped;

    window_result_t expected_results [$];
    int             pending;
    int             errors;
    int             items_sent;
    int             results_seen;
    int             sequences_sent;
    int             peak_longest;
    bit             steady;

    stim_row_t directed [DIR_ROWS];
    int        perm [DEPTH];

    always #5 aclk = ~aclk;

    longest_distinct_window #(
        .VALUE_BITS(VALUE_BITS),
        .POS_BITS  (POS_BITS)
    ) dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_value         (s_value),
        .s_first_item    (s_first_item),
        .s_last_item     (s_last_item),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_longest       (m_longest),
        .m_final_result  (m_final_result),
        .m_count_overflow(m_count_overflow)
    );

    // Advance the window by one value and return the result it causes.
    function automatic window_result_t advance_window(
        input logic [VALUE_BITS-1:0] v,
        input logic                  first,
        input logic                  last
    );
        logic [POS_BITS-1:0] pos;
        logic [POS_BITS-1:0] prev;
        logic [POS_BITS-1:0] len;
        window_result_t      r;
        pos = pos_count + 1'b1;
        pos_count = pos;
        if (pos == '0) begin
            pos_wrapped = 1'b1;
        end
        // A new sequence drops the old window; older table entries then
        // sit before the start and count as unseen.
        if (first) begin
            run_start = pos;
            best_run  = '0;
        end
        prev = seen_at[v];
        if (prev >= run_start) begin
            run_start = prev + 1'b1;
        end
        seen_at[v] = pos;
        len = pos - run_start + 1'b1;
        // Hold the length to the table depth; it never exceeds the port range.
        if (len > DEPTH) begin
            len = POS_BITS'(DEPTH);
        end
        if (len > best_run) begin
            best_run = len[LW-1:0];
        end
        r.longest        = best_run;
        r.final_result   = last;
        r.count_overflow = pos_wrapped;
        return r;
    endfunction

    // Present one beat, hold it until accepted, then queue its expectation.
    task automatic send_item(
        input logic [VALUE_BITS-1:0] v,
        input logic                  first,
        input logic                  last,
        input logic                  known,
        input logic [LW-1:0]         typed_longest
    );
        window_result_t r;
        if (!steady) begin
            while ($urandom_range(99) < IDLE_PCT) begin
                s_valid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_valid      <= 1'b1;
        s_value      <= v;
        s_first_item <= first;
        s_last_item  <= last;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        // The predictor always advances; a typed row overrides only longest.
        r = advance_window(v, first, last);
        if (known) begin
            r.longest = typed_longest;
        end
        expected_results.push_back(r);
        pending++;
        items_sent++;
        if (first) begin
            sequences_sent++;
        end
    endtask

    // Send a sequence of n values drawn from a window of alpha values that
    // starts at a random base, so repeats are as dense as alpha makes them.
    task automatic send_sequence(
        input int n,
        input int alpha,
        input bit mark_first,
        input bit mark_last
    );
        int base;
        int k;
        base = $urandom_range(DEPTH - 1);
        for (k = 0; k < n; k++) begin
            send_item(VALUE_BITS'((base + $urandom_range(alpha - 1)) % DEPTH),
                      mark_first && (k == 0), mark_last && (k == n - 1), 1'b0, '0);
        end
    endtask

    // Result side: check the beat taken at this edge, then pick the next
    // ready level. Both reads see values from before the edge.
    always @(posedge aclk) begin
        window_result_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (m_longest > peak_longest) begin
                peak_longest = int'(m_longest);
            end
            if (expected_results.size() == 0) begin
                $display("%0t: result beat with nothing expected: longest %0d final %0d ovf %0d",
                         $time, m_longest, m_final_result, m_count_overflow);
                errors++;
            end else begin
                want = expected_results.pop_front();
                pending--;
                if (m_longest !== want.longest) begin
                    $display("%0t: longest mismatch: expected %0d, actual %0d",
                             $time, want.longest, m_longest);
                    errors++;
                end
                if (m_final_result !== want.final_result) begin
                    $display("%0t: final_result mismatch: expected %0d, actual %0d",
                             $time, want.final_result, m_final_result);
                    errors++;
                end
                if (m_count_overflow !== want.count_overflow) begin
                    $display("%0t: count_overflow mismatch: expected %0d, actual %0d",
                             $time, want.count_overflow, m_count_overflow);
                    errors++;
                end
            end
        end
        m_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end

    // Run limit: far beyond the slowest correct run, the reset sweep included.
    initial begin
        #5_000_000;
        $display("tb_longest_distinct_window: errors");
        $finish;
    end

    initial begin
        int i;
        int j;
        int t;
        int mode;
        int alpha;
        int n;
        int rand_sent;

        for (i = 0; i < DEPTH; i++) begin
            seen_at[i] = '0;
        end
        pos_count   = '0;
        run_start   = POS_BITS'(1);
        best_run    = '0;
        pos_wrapped = 1'b0;

        // value, first, last, known, longest
        directed = '{
            // items before any first flag form a sequence from position 1
            '{10'd0,    1'b0, 1'b0, 1'b1, 11'd1},
            '{10'd1023, 1'b0, 1'b0, 1'b1, 11'd2},
            '{10'd0,    1'b0, 1'b1, 1'b1, 11'd2},
            // immediate repeats keep the window at one
            '{10'd5,    1'b1, 1'b0, 1'b1, 11'd1},
            '{10'd5,    1'b0, 1'b0, 1'b1, 11'd1},
            '{10'd5,    1'b0, 1'b1, 1'b1, 11'd1},
            // entries from older sequences are stale
            '{10'd0,    1'b1, 1'b0, 1'b1, 11'd1},
            '{10'd1023, 1'b0, 1'b0, 1'b1, 11'd2},
            '{10'd682,  1'b0, 1'b0, 1'b1, 11'd3},
            '{10'd341,  1'b0, 1'b0, 1'b1, 11'd4},
            '{10'd1023, 1'b0, 1'b0, 1'b1, 11'd4},
            '{10'd0,    1'b0, 1'b1, 1'b1, 11'd4},
            // single-item sequence
            '{10'd7,    1'b1, 1'b1, 1'b1, 11'd1},
            '{10'd1,    1'b1, 1'b0, 1'b0, 11'd0},
            '{10'd2,    1'b0, 1'b0, 1'b0, 11'd0},
            '{10'd3,    1'b0, 1'b0, 1'b0, 11'd0},
            '{10'd1,    1'b0, 1'b0, 1'b0, 11'd0},
            '{10'd2,    1'b0, 1'b0, 1'b0, 11'd0},
            '{10'd3,    1'b0, 1'b0, 1'b0, 11'd0},
            '{10'd4,    1'b0, 1'b1, 1'b0, 11'd0}
        };

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed rows; the block's table sweep after reset simply holds
        // off the first beat.
        for (i = 0; i < DIR_ROWS; i++) begin
            send_item(directed[i].value, directed[i].first, directed[i].last,
                      directed[i].known, directed[i].longest);
        end

        // Drain completely before going on.
        s_valid <= 1'b0;
        while (pending != 0) begin
            @(posedge aclk);
        end
        @(posedge aclk);

        // One sequence holding every value once, with no idling on either
        // side, then a few repeats: the window reaches the full table depth.
        for (i = 0; i < DEPTH; i++) begin
            perm[i] = i;
        end
        for (i = DEPTH - 1; i > 0; i--) begin
            j       = $urandom_range(i);
            t       = perm[i];
            perm[i] = perm[j];
            perm[j] = t;
        end
        steady = 1'b1;
        for (i = 0; i < DEPTH; i++) begin
            send_item(VALUE_BITS'(perm[i]), i == 0, 1'b0, 1'b0, '0);
        end
        steady = 1'b0;
        for (i = 0; i < 4; i++) begin
            send_item(VALUE_BITS'(perm[$urandom_range(DEPTH - 1)]), 1'b0, i == 3,
                      1'b0, '0);
        end

        // Random part: mostly well-formed sequences, some missing a flag,
        // some pure noise with random flags on every beat.
        rand_sent = 0;
        while (rand_sent < RAND_ITEMS) begin
            mode = $urandom_range(9);
            case ($urandom_range(4))
                0: alpha = 2;
                1: alpha = 4;
                2: alpha = 16;
                3: alpha = 64;
                default: alpha = DEPTH;
            endcase
            n = (alpha == DEPTH) ? $urandom_range(1, 120) : $urandom_range(1, 40);
            if (mode == 0) begin
                for (i = 0; i < n; i++) begin
                    send_item(VALUE_BITS'($urandom_range(DEPTH - 1)),
                              1'($urandom_range(1)), 1'($urandom_range(1)), 1'b0, '0);
                end
            end else begin
                send_sequence(n, alpha, mode != 1, mode != 2);
            end
            rand_sent += n;
            // Now and then stop sending until every result is back.
            if ($urandom_range(19) == 0) begin
                s_valid <= 1'b0;
                while (pending != 0) begin
                    @(posedge aclk);
                end
                @(posedge aclk);
            end
        end
        s_valid <= 1'b0;

        // Drain, then keep watching for stray beats before the summary.
        while (pending != 0) begin
            @(posedge aclk);
        end
        repeat (8) @(posedge aclk);

        $display("Sent %0d beats over %0d flagged sequences; checked %0d results.",
                 items_sent, sequences_sent, results_seen);
        $display("Longest window reported: %0d of %0d values.", peak_longest, DEPTH);
        if (errors == 0) begin
            $display("tb_longest_distinct_window: clean");
        end else begin
            $display("tb_longest_distinct_window: errors");
        end
        $finish;
    end

endmodule
